// ===== rtl/vpa_pkg.sv =====
// Package with shared constants, codes and the cell command type of the partition allocator.
package vpa_pkg;

  localparam int LenW        = 15;
  localparam int DefMaxSeg   = 64;
  localparam int DefPoolSize = 32767;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_CONFLICT = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic POL_FIRST = 1'b0;
  localparam logic POL_BEST  = 1'b1;

  localparam logic [2:0] CMD_HOLD = 3'd0;
  localparam logic [2:0] CMD_ROT  = 3'd1;
  localparam logic [2:0] CMD_REM  = 3'd2;
  localparam logic [2:0] CMD_INS  = 3'd3;
  localparam logic [2:0] CMD_UPD  = 3'd4;

  typedef struct packed {
    logic [2:0]      op;
    logic [LenW-1:0] start;
    logic [LenW-1:0] len;
  } cell_cmd_t;

endpackage

// ===== rtl/vpa_cell.sv =====
// One cell of the segment chain: holds a single free segment and trades it with its neighbors.
module vpa_cell
  import vpa_pkg::*;
#(
  parameter int CW        = 7,
  parameter int K         = 0,
  parameter int POOL_SIZE = DefPoolSize
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_cmd_t       cmd,
  input  logic [CW-1:0]   target,
  input  logic [LenW-1:0] left_start,
  input  logic [LenW-1:0] left_len,
  input  logic [LenW-1:0] right_start,
  input  logic [LenW-1:0] right_len,
  output logic [LenW-1:0] start_r,
  output logic [LenW-1:0] len_r
);

  localparam logic [CW-1:0] KIdx = CW'(K);

  logic [LenW-1:0] start_nxt;
  logic [LenW-1:0] len_nxt;

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    unique case (cmd.op)
      CMD_ROT: begin
        start_nxt = right_start;
        len_nxt   = right_len;
      end
      CMD_REM: begin
        if (KIdx >= target) begin
          start_nxt = right_start;
          len_nxt   = right_len;
        end
      end
      CMD_INS: begin
        if (KIdx > target) begin
          start_nxt = left_start;
          len_nxt   = left_len;
        end else if (KIdx == target) begin
          start_nxt = cmd.start;
          len_nxt   = cmd.len;
        end
      end
      CMD_UPD: begin
        if (KIdx == target) begin
          start_nxt = cmd.start;
          len_nxt   = cmd.len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= (K == 0) ? LenW'(POOL_SIZE) : '0;
    end else begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== rtl/variable_partition_allocator.sv =====
// Top level of the variable-partition allocator: sequencer, trackers and the chain of cells.
//
// Usage: each input word is an allocate (action 0, block_size) or a release (action 1,
// block_size, release_start); each produces exactly one output word with status and
// granted_start. Both channels use valid/stall; a word moves when valid is high and stall
// is low. The free segments live in a ring of MAX_SEGMENTS cells sorted by address.
// An item rotates the ring once around while the head cell is inspected, then inserts,
// removes or updates one segment (a release that joins two segments first grows the lower
// one, then removes the upper one) and loads the output register. A zero size or an
// out-of-pool release skips the scan and goes straight to loading the output register.
// One item is worked on at a time; in_stall is high while it is in progress. The result
// sits in an output register, so a new word is taken while a result still waits on
// out_stall; a finished item waits only if the previous result is still held. fit_policy
// is written through cfg_we and cfg_wdata; the user must write it only while the block
// is idle, as the block itself does not enforce this. Reset (rst_n low, synchronous)
// leaves one free segment covering the whole pool, first fit selected and no result
// pending.
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int MAX_SEGMENTS = DefMaxSeg,
  parameter int POOL_SIZE    = DefPoolSize
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_action,
  input  logic [LenW-1:0] in_block_size,
  input  logic [LenW-1:0] in_release_start,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_status,
  output logic [LenW-1:0] out_granted_start
);

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_SEGMENTS);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_SEGMENTS - 1);
  localparam logic [LenW:0] PoolW   = (LenW + 1)'(POOL_SIZE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_APP1 = 3'd2;
  localparam logic [2:0] S_APP2 = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic            pol_r;
  logic            act_r;
  logic [LenW-1:0] n_r, s_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   idx_r;
  logic [2:0]      res_status_r, res_status_nxt;
  logic [LenW-1:0] res_grant_r, res_grant_nxt;
  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [LenW-1:0] out_grant_r;

  // Scan trackers.
  logic            found_r;
  logic [CW-1:0]   pick_r;
  logic [LenW-1:0] pstart_r, plen_r;
  logic            conf_r;
  logic [CW-1:0]   p_r;
  logic [LenW:0]   lend_r;
  logic [LenW-1:0] llen_r;
  logic            rfound_r;
  logic [LenW-1:0] rstart_r, rlen_r;

  cell_cmd_t       cmd;
  logic [CW-1:0]   target;
  logic [LenW-1:0] cstart [MAX_SEGMENTS];
  logic [LenW-1:0] clen   [MAX_SEGMENTS];

  logic            accept;
  logic            head_valid;
  logic [LenW:0]   head_end, s_plus_n, in_end;
  logic            left_ok, right_ok;

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    vpa_cell #(.CW(CW), .K(k), .POOL_SIZE(POOL_SIZE)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .target     (target),
      .left_start (cstart[(k + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
      .left_len   (clen[(k + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
      .right_start(cstart[(k + 1) % MAX_SEGMENTS]),
      .right_len  (clen[(k + 1) % MAX_SEGMENTS]),
      .start_r    (cstart[k]),
      .len_r      (clen[k])
    );
  end

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign head_valid = (CW'(idx_r) < count_r);
  assign head_end   = {1'b0, cstart[0]} + {1'b0, clen[0]};
  assign s_plus_n   = {1'b0, s_r} + {1'b0, n_r};
  assign in_end     = {1'b0, in_release_start} + {1'b0, in_block_size};
  assign left_ok    = (p_r != '0) && (lend_r == {1'b0, s_r});
  assign right_ok   = rfound_r && ({1'b0, rstart_r} == s_plus_n);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    cmd            = '{op: CMD_HOLD, start: '0, len: '0};
    target         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_grant_nxt = '0;
          if (in_block_size == '0) begin
            res_status_nxt = ST_ZERO;
            state_nxt      = S_DONE;
          end else if (in_action == ACT_RELEASE && in_end > PoolW) begin
            res_status_nxt = ST_CONFLICT;
            state_nxt      = S_DONE;
          end else begin
            res_status_nxt = ST_OK;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.op = CMD_ROT;
        if (idx_r == LastIdx) state_nxt = S_APP1;
      end
      S_APP1: begin
        state_nxt = S_DONE;
        if (act_r == ACT_ALLOC) begin
          if (!found_r) begin
            res_status_nxt = ST_NOFIT;
          end else begin
            res_grant_nxt = pstart_r;
            target        = pick_r;
            if (plen_r == n_r) begin
              cmd.op    = CMD_REM;
              count_nxt = count_r - 1'b1;
            end else begin
              cmd = '{op: CMD_UPD, start: pstart_r + n_r, len: plen_r - n_r};
            end
          end
        end else if (conf_r) begin
          res_status_nxt = ST_CONFLICT;
        end else if (left_ok && right_ok) begin
          // Range closes the gap between two segments: grow the lower, then drop the upper.
          target    = p_r - 1'b1;
          cmd       = '{op: CMD_UPD, start: '0, len: llen_r + n_r + rlen_r};
          cmd.start = LenW'(lend_r - {1'b0, llen_r});
          state_nxt = S_APP2;
        end else if (left_ok) begin
          target    = p_r - 1'b1;
          cmd       = '{op: CMD_UPD, start: '0, len: llen_r + n_r};
          cmd.start = LenW'(lend_r - {1'b0, llen_r});
        end else if (right_ok) begin
          target = p_r;
          cmd    = '{op: CMD_UPD, start: s_r, len: rlen_r + n_r};
        end else if (count_r == MaxCnt) begin
          res_status_nxt = ST_FULL;
        end else begin
          target    = p_r;
          cmd       = '{op: CMD_INS, start: s_r, len: n_r};
          count_nxt = count_r + 1'b1;
        end
      end
      S_APP2: begin
        target    = p_r;
        cmd.op    = CMD_REM;
        count_nxt = count_r - 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      pol_r       <= POL_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) pol_r <= cfg_wdata;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_status_r <= res_status_r;
      out_grant_r  <= (res_status_r == ST_OK) ? res_grant_r : '0;
    end
    if (accept) begin
      act_r    <= in_action;
      n_r      <= in_block_size;
      s_r      <= in_release_start;
      idx_r    <= '0;
      found_r  <= 1'b0;
      pick_r   <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      conf_r   <= 1'b0;
      p_r      <= '0;
      lend_r   <= '0;
      llen_r   <= '0;
      rfound_r <= 1'b0;
      rstart_r <= '0;
      rlen_r   <= '0;
    end else if (state_r == S_SCAN) begin
      idx_r <= idx_r + 1'b1;
      if (head_valid) begin
        if (clen[0] >= n_r &&
            (!found_r || (pol_r == POL_BEST && clen[0] < plen_r))) begin
          found_r  <= 1'b1;
          pick_r   <= CW'(idx_r);
          pstart_r <= cstart[0];
          plen_r   <= clen[0];
        end
        if ({1'b0, s_r} < head_end && {1'b0, cstart[0]} < s_plus_n) conf_r <= 1'b1;
        if (cstart[0] < s_r) begin
          p_r    <= CW'(idx_r) + 1'b1;
          lend_r <= head_end;
          llen_r <= clen[0];
        end else if (!rfound_r) begin
          rfound_r <= 1'b1;
          rstart_r <= cstart[0];
          rlen_r   <= clen[0];
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_grant_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxCnt) else $error("segment count exceeds table size");

  a_accept_to_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN || state_r == S_DONE))
    else $error("accepted word did not start work");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_grant_r == '0)
    else $error("nonzero grant on failed request");

  a_count_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> $stable(count_r))
    else $error("segment count changed during scan");

endmodule

// ===== tb/variable_partition_allocator_checker.sv =====
// Checker that predicts the free-segment table of the allocator and compares every result word.
`timescale 1ns / 100ps
module variable_partition_allocator_checker
  import vpa_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic            in_action,
  input  logic [LenW-1:0] in_block_size,
  input  logic [LenW-1:0] in_release_start,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [2:0]      out_status,
  input  logic [LenW-1:0] out_granted_start,
  output int              fail_count,
  output int              pending
);

  localparam int Slots = DefMaxSeg;
  localparam int Pool  = DefPoolSize;

  typedef struct packed {
    logic [2:0]      status;
    logic [LenW-1:0] grant;
  } outcome_t;

  int       free_base[Slots];
  int       free_len[Slots];
  int       free_count;
  logic     policy;
  outcome_t outcome_q[$];

  // Close the gap at entry p by moving the entries above it down by one.
  function automatic void drop_segment(int p);
    for (int i = p; i + 1 < free_count; i++) begin
      free_base[i] = free_base[i + 1];
      free_len[i]  = free_len[i + 1];
    end
    free_count--;
  endfunction

  function automatic outcome_t grant_block(int n);
    outcome_t r;
    int pick;
    bit found;
    r = '0;
    pick = 0;
    found = 0;
    for (int i = 0; i < free_count; i++) begin
      if (free_len[i] >= n &&
          (!found || (policy == POL_BEST && free_len[i] < free_len[pick]))) begin
        pick = i;
        found = 1;
        if (policy == POL_FIRST) break;
      end
    end
    if (!found) begin
      r.status = ST_NOFIT;
      return r;
    end
    r.status = ST_OK;
    r.grant = LenW'(free_base[pick]);
    if (free_len[pick] == n) drop_segment(pick);
    else begin
      free_base[pick] += n;
      free_len[pick]  -= n;
    end
    return r;
  endfunction

  function automatic logic [2:0] return_range(int s, int n);
    int p;
    bit left;
    bit right;
    p = 0;
    if (s + n > Pool) return ST_CONFLICT;
    for (int i = 0; i < free_count; i++) begin
      if (s < free_base[i] + free_len[i] && free_base[i] < s + n) return ST_CONFLICT;
      if (free_base[i] < s) p = i + 1;
    end
    left  = p > 0 && free_base[p - 1] + free_len[p - 1] == s;
    right = p < free_count && s + n == free_base[p];
    if (left && right) begin
      free_len[p - 1] += n + free_len[p];
      drop_segment(p);
    end else if (left) begin
      free_len[p - 1] += n;
    end else if (right) begin
      free_base[p] = s;
      free_len[p] += n;
    end else begin
      if (free_count >= Slots) return ST_FULL;
      for (int i = free_count; i > p; i--) begin
        free_base[i] = free_base[i - 1];
        free_len[i]  = free_len[i - 1];
      end
      free_base[p] = s;
      free_len[p] = n;
      free_count++;
    end
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      free_base[0] = 0;
      free_len[0] = Pool;
      free_count = 1;
      policy = POL_FIRST;
      outcome_q.delete();
      pending = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) policy = cfg_wdata;
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.grant = out_granted_start;
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected word, actual status %0d start %0d", $time, got.status,
                   got.grant);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (want != got) begin
            $display("%0t: mismatch, expected status %0d start %0d, actual status %0d start %0d",
                     $time, want.status, want.grant, got.status, got.grant);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = '0;
        if (in_block_size == 0) want.status = ST_ZERO;
        else if (in_action == ACT_ALLOC) want = grant_block(in_block_size);
        else want.status = return_range(in_release_start, in_block_size);
        outcome_q.insert(outcome_q.size(), want);
      end
      pending = outcome_q.size();
    end
  end

endmodule

// ===== tb/variable_partition_allocator_test.sv =====
// Testbench top: clock, reset, stimulus with bursts and stalls, and the verdict.
`timescale 1ns / 100ps
module variable_partition_allocator_test;
  import vpa_pkg::*;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic            cfg_wdata;
  logic            in_valid;
  logic            in_stall;
  logic            in_action;
  logic [LenW-1:0] in_block_size;
  logic [LenW-1:0] in_release_start;
  logic            out_valid;
  logic            out_stall;
  logic [2:0]      out_status;
  logic [LenW-1:0] out_granted_start;
  int              fail_count;
  int              pending;
  int              hold_off;
  int              burst_left;

  variable_partition_allocator DUT (.*);

  variable_partition_allocator_checker checker_inst (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #400ms;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall pattern, plus a long hold-off when requested.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off = hold_off - 1;
      end else begin
        case ($urandom_range(3))
          0: out_stall <= ($urandom_range(9) < 7);
          1: out_stall <= 0;
          default: out_stall <= ($urandom_range(9) < 2);
        endcase
      end
    end
  end

  task automatic send_word(logic act, int n, int s);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(200)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1;
    in_action <= act;
    in_block_size <= LenW'(n);
    in_release_start <= LenW'(s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) in_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_policy(logic p);
    drain();
    cfg_we <= 1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int n;
    int s;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_action = 0;
    in_block_size = 0;
    in_release_start = 0;
    hold_off = 0;
    burst_left = 1;
    rst_n = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed part: zero sizes, oversize, whole pool, exact fit, out of pool, overlap, merges.
    send_word(ACT_ALLOC, 0, 0);
    send_word(ACT_RELEASE, 0, 32767);
    send_word(ACT_ALLOC, 32767, 0);
    send_word(ACT_ALLOC, 1, 0);
    send_word(ACT_RELEASE, 32767, 0);
    send_word(ACT_RELEASE, 1, 32767);
    send_word(ACT_ALLOC, 100, 0);
    send_word(ACT_ALLOC, 200, 0);
    send_word(ACT_ALLOC, 300, 0);
    send_word(ACT_RELEASE, 100, 0);
    send_word(ACT_RELEASE, 50, 50);
    send_word(ACT_RELEASE, 10, 595);
    send_word(ACT_RELEASE, 100, 0);
    send_word(ACT_RELEASE, 300, 300);
    send_word(ACT_RELEASE, 200, 100);
    send_word(ACT_RELEASE, 20000, 16384);
    send_word(ACT_ALLOC, 32767, 0);
    // Fill the table with single-unit holes, then one more hole must be refused.
    for (int i = 0; i < 65; i++) send_word(ACT_RELEASE, 1, 2 * i);
    send_word(ACT_RELEASE, 1, 200);
    set_policy(POL_BEST);
    send_word(ACT_ALLOC, 1, 0);
    send_word(ACT_RELEASE, 32767 - 130, 130);
    send_word(ACT_ALLOC, 2, 0);

    // Random part in four phases, switching the fit policy between them.
    for (int ph = 0; ph < 4; ph++) begin
      set_policy(ph[0] ? POL_FIRST : POL_BEST);
      if (ph == 1) hold_off = 400;
      for (int k = 0; k < 90; k++) begin
        case ($urandom_range(9))
          0: send_word(1'($urandom_range(1)), $urandom_range(32767), $urandom_range(32767));
          1, 2, 3, 4: begin
            n = ($urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(1, 600);
            send_word(ACT_ALLOC, n, $urandom_range(32767));
          end
          default: begin
            // Release a random small range, mostly inside the low part that gets allocated.
            n = $urandom_range(1, 300);
            s = $urandom_range(20000);
            if ($urandom_range(15) == 0) s = 32767 - $urandom_range(n);
            send_word(ACT_RELEASE, n, s);
          end
        endcase
        if (k == 45 && ph == 2) drain();
      end
    end

    drain();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vpa_pkg.sv
rtl/vpa_cell.sv
rtl/variable_partition_allocator.sv
tb/variable_partition_allocator_checker.sv
tb/variable_partition_allocator_test.sv
